FILE: hw/rtl/fit_policy_block_allocator_defines.svh
// Assertion macros for the fit-policy block allocator.
// Used by fit_policy_block_allocator.sv; expects clk and rst_n in scope.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define FPBA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define FPBA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/fpba_pkg.sv
// Shared constants for the fit-policy block allocator.
// No dependencies; imported by fit_policy_block_allocator.
`default_nettype none

package fpba_pkg;

    // Table geometry
    localparam int MAX_BLOCKS   = 64;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W       = 32;
    localparam int SIZE_W       = 24;
    localparam int ENT_W        = ADDR_W + SIZE_W;
    localparam int OUT_IDX_W    = 6;
    localparam int STATUS_W     = 3;
    localparam int POLICY_W     = 2;
    localparam int CFG_IDX_W    = 1;

    localparam logic [ADDR_W-1:0] HEADER_BYTES = 32'd32;
    localparam logic [ADDR_W-1:0] HEAP_LIMIT_RESET = 32'd1048576;

    // Operation codes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Fit policies
    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;
    localparam logic [POLICY_W-1:0] POL_NEXT  = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_MEM    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NULL_FREE = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'd1;

endpackage

`default_nettype wire

FILE: hw/rtl/fpba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module fpba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fit_policy_block_allocator.sv
// Top level of the fit-policy heap block allocator.
// Depends on fpba_pkg, fpba_ram and fit_policy_block_allocator_defines.svh.
`default_nettype none
`include "fit_policy_block_allocator_defines.svh"

// An item is taken when start is high and busy is low. Allocates with a
// zero or oversized request and frees of a null address answer on the next
// cycle. Every other item walks the block table through its RAM read port,
// one entry per cycle, then passes through S_DRAIN and S_FINISH before its
// answer; with an empty table there is nothing to walk and it goes straight
// to S_FINISH. The result shows for one cycle with done high and cannot be
// held off; busy drops in that same cycle, so the next item may be started
// right away. The user must make configuration writes only while busy is
// low; the block itself does not enforce this.
module fit_policy_block_allocator (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [fpba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [31:0]                       cfg_data,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              mode,
    input  wire logic [fpba_pkg::SIZE_W-1:0]       req_size,
    input  wire logic [fpba_pkg::ADDR_W-1:0]       free_addr,
    output logic                                   done,
    output logic      [fpba_pkg::STATUS_W-1:0]     status,
    output logic      [fpba_pkg::OUT_IDX_W-1:0]    block_index,
    output logic      [fpba_pkg::ADDR_W-1:0]       data_addr,
    output logic      [fpba_pkg::SIZE_W-1:0]       block_size,
    output logic                                   reused
);

    import fpba_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    // Control and state registers
    logic [1:0]            state_reg,   state_next;
    logic [POLICY_W-1:0]   policy_reg,  policy_next;
    logic [ADDR_W-1:0]     limit_reg,   limit_next;
    logic [MAX_BLOCKS-1:0] free_reg,    free_next;
    logic [CNT_W-1:0]      count_reg,   count_next;
    logic [ADDR_W-1:0]     heap_reg,    heap_next;
    logic [IDX_W-1:0]      rover_reg,   rover_next;
    logic [IDX_W-1:0]      k_reg,       k_next;
    logic [IDX_W-1:0]      iss_reg,     iss_next;
    logic                  ev_vld_reg,  ev_vld_next;
    logic [IDX_W-1:0]      ev_idx_reg,  ev_idx_next;
    logic                  found_reg,   found_next;
    logic                  done_reg,    done_next;

    // Payload registers
    logic                  op_reg,      op_next;
    logic [SIZE_W-1:0]     size_reg,    size_next;
    logic [ADDR_W-1:0]     faddr_reg,   faddr_next;
    logic [IDX_W-1:0]      pk_idx_reg,  pk_idx_next;
    logic [SIZE_W-1:0]     pk_size_reg, pk_size_next;
    logic [ADDR_W-1:0]     pk_start_reg, pk_start_next;
    logic                  pk_free_reg, pk_free_next;
    logic [STATUS_W-1:0]   status_reg,  status_next;
    logic [OUT_IDX_W-1:0]  bidx_reg,    bidx_next;
    logic [ADDR_W-1:0]     daddr_reg,   daddr_next;
    logic [SIZE_W-1:0]     bsize_reg,   bsize_next;
    logic                  reused_reg,  reused_next;

    // Table RAM: {start, size} per entry
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ENT_W-1:0]      ram_wdata;
    logic [ENT_W-1:0]      ram_rdata;
    logic [ADDR_W-1:0]     rd_start;
    logic [SIZE_W-1:0]     rd_size;

    logic                  accept;
    logic [SIZE_W:0]       rnd_size;
    logic [IDX_W-1:0]      scan_first;
    logic                  fit;
    logic                  take;
    logic                  match;
    logic [ADDR_W+1:0]     need;
    logic                  no_room;

    fpba_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (k_reg),
        .rdata (ram_rdata)
    );

    assign rd_start = ram_rdata[ENT_W-1:SIZE_W];
    assign rd_size  = ram_rdata[SIZE_W-1:0];

    assign accept   = start && (state_reg == S_IDLE);
    assign rnd_size = ({1'b0, req_size} + (SIZE_W+1)'(3)) & ~(SIZE_W+1)'(3);

    // Next fit starts at the rover when it points inside the table
    assign scan_first = (policy_reg == POL_NEXT && {1'b0, rover_reg} < count_reg)
                        ? rover_reg : '0;

    // Evaluation of the entry returned by the RAM
    assign fit   = free_reg[ev_idx_reg] && (rd_size >= size_reg);
    assign take  = fit && (!found_reg
                   || (policy_reg == POL_BEST  && rd_size < pk_size_reg)
                   || (policy_reg == POL_WORST && rd_size > pk_size_reg));
    assign match = ({1'b0, rd_start} + {1'b0, HEADER_BYTES}) == {1'b0, faddr_reg};

    // Growth check, computed without wrap
    assign need    = {2'b00, heap_reg} + {2'b00, HEADER_BYTES}
                     + {{(ADDR_W+2-SIZE_W){1'b0}}, size_reg};
    assign no_room = (count_reg >= CNT_W'(MAX_BLOCKS)) || (need > {2'b00, limit_reg});

    // Sequencer and datapath next state
    always_comb
    begin
        state_next    = state_reg;
        policy_next   = policy_reg;
        limit_next    = limit_reg;
        free_next     = free_reg;
        count_next    = count_reg;
        heap_next     = heap_reg;
        rover_next    = rover_reg;
        k_next        = k_reg;
        iss_next      = iss_reg;
        ev_vld_next   = 1'b0;
        ev_idx_next   = k_reg;
        found_next    = found_reg;
        done_next     = 1'b0;
        op_next       = op_reg;
        size_next     = size_reg;
        faddr_next    = faddr_reg;
        pk_idx_next   = pk_idx_reg;
        pk_size_next  = pk_size_reg;
        pk_start_next = pk_start_reg;
        pk_free_next  = pk_free_reg;
        status_next   = status_reg;
        bidx_next     = bidx_reg;
        daddr_next    = daddr_reg;
        bsize_next    = bsize_reg;
        reused_next   = reused_reg;
        ram_we        = 1'b0;
        ram_waddr     = count_reg[IDX_W-1:0];
        ram_wdata     = {heap_reg, size_reg};

        // Configuration writes
        if (cfg_we)
        begin
            if (cfg_index == CFG_FIT_POLICY)
            begin
                policy_next = cfg_data[POLICY_W-1:0];
            end
            else if (cfg_index == CFG_HEAP_LIMIT)
            begin
                limit_next = cfg_data;
            end
        end

        // Pick or match update from the entry under evaluation
        if (ev_vld_reg)
        begin
            if (op_reg == MODE_ALLOC)
            begin
                if (take)
                begin
                    found_next    = 1'b1;
                    pk_idx_next   = ev_idx_reg;
                    pk_size_next  = rd_size;
                    pk_start_next = rd_start;
                end
            end
            else if (match && !found_reg)
            begin
                found_next   = 1'b1;
                pk_idx_next  = ev_idx_reg;
                pk_size_next = rd_size;
                pk_free_next = free_reg[ev_idx_reg];
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = mode;
                    size_next  = rnd_size[SIZE_W-1:0];
                    faddr_next = free_addr;
                    found_next = 1'b0;
                    k_next     = scan_first;
                    iss_next   = '0;
                    status_next = ST_OK;
                    bidx_next   = '0;
                    daddr_next  = '0;
                    bsize_next  = '0;
                    reused_next = 1'b0;
                    if (mode == MODE_ALLOC && req_size == '0)
                    begin
                        status_next = ST_ZERO_SIZE;
                        done_next   = 1'b1;
                    end
                    else if (mode == MODE_ALLOC && rnd_size[SIZE_W])
                    begin
                        status_next = ST_NO_MEM;
                        done_next   = 1'b1;
                    end
                    else if (mode == MODE_FREE && free_addr == '0)
                    begin
                        status_next = ST_NULL_FREE;
                        done_next   = 1'b1;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Issue one read per cycle in scan order, wrapping at the count
                ev_vld_next = 1'b1;
                ev_idx_next = k_reg;
                iss_next    = iss_reg + 1'b1;
                if ({1'b0, k_reg} + 1'b1 == count_reg)
                begin
                    k_next = '0;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
                if ({1'b0, iss_reg} == CNT_W'(count_reg - 1'b1))
                begin
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (op_reg == MODE_ALLOC)
                begin
                    if (found_reg)
                    begin
                        free_next[pk_idx_reg] = 1'b0;
                        rover_next  = pk_idx_reg;
                        status_next = ST_OK;
                        bidx_next   = OUT_IDX_W'(pk_idx_reg);
                        daddr_next  = pk_start_reg + HEADER_BYTES;
                        bsize_next  = pk_size_reg;
                        reused_next = 1'b1;
                    end
                    else if (no_room)
                    begin
                        status_next = ST_NO_MEM;
                    end
                    else
                    begin
                        // Append a new block at the top of the heap
                        ram_we      = 1'b1;
                        free_next[count_reg[IDX_W-1:0]] = 1'b0;
                        count_next  = count_reg + 1'b1;
                        heap_next   = need[ADDR_W-1:0];
                        rover_next  = count_reg[IDX_W-1:0];
                        status_next = ST_OK;
                        bidx_next   = OUT_IDX_W'(count_reg[IDX_W-1:0]);
                        daddr_next  = heap_reg + HEADER_BYTES;
                        bsize_next  = size_reg;
                        reused_next = 1'b0;
                    end
                end
                else if (found_reg && !pk_free_reg)
                begin
                    free_next[pk_idx_reg] = 1'b1;
                    status_next = ST_OK;
                    bidx_next   = OUT_IDX_W'(pk_idx_reg);
                    daddr_next  = faddr_reg;
                    bsize_next  = pk_size_reg;
                end
                else
                begin
                    status_next = ST_BAD_FREE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            policy_reg <= POL_FIRST;
            limit_reg  <= HEAP_LIMIT_RESET;
            free_reg   <= '0;
            count_reg  <= '0;
            heap_reg   <= '0;
            rover_reg  <= '0;
            k_reg      <= '0;
            iss_reg    <= '0;
            ev_vld_reg <= 1'b0;
            ev_idx_reg <= '0;
            found_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            policy_reg <= policy_next;
            limit_reg  <= limit_next;
            free_reg   <= free_next;
            count_reg  <= count_next;
            heap_reg   <= heap_next;
            rover_reg  <= rover_next;
            k_reg      <= k_next;
            iss_reg    <= iss_next;
            ev_vld_reg <= ev_vld_next;
            ev_idx_reg <= ev_idx_next;
            found_reg  <= found_next;
            done_reg   <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        size_reg     <= size_next;
        faddr_reg    <= faddr_next;
        pk_idx_reg   <= pk_idx_next;
        pk_size_reg  <= pk_size_next;
        pk_start_reg <= pk_start_next;
        pk_free_reg  <= pk_free_next;
        status_reg   <= status_next;
        bidx_reg     <= bidx_next;
        daddr_reg    <= daddr_next;
        bsize_reg    <= bsize_next;
        reused_reg   <= reused_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign block_index = bidx_reg;
    assign data_addr   = daddr_reg;
    assign block_size  = bsize_reg;
    assign reused      = reused_reg;

    // Checks
    `FPBA_ASSERT_IMP(a_done_idle, done, !busy, "result beat while sequencer busy")
    `FPBA_ASSERT_NXT(a_accept_resp, accept, busy || done, "accepted item left no trace")
    `FPBA_ASSERT_IMP(a_err_zero, done && status != ST_OK,
        block_index == '0 && data_addr == '0 && block_size == '0 && !reused,
        "error result carries nonzero fields")
    `FPBA_ASSERT_IMP(a_count_max, 1'b1, count_reg <= CNT_W'(MAX_BLOCKS),
        "entry count beyond table depth")
    `FPBA_ASSERT_IMP(a_scan_bound, state_reg == S_SCAN, {1'b0, iss_reg} < count_reg,
        "scan ran past the entry count")

endmodule

`default_nettype wire
